// ===== rtl/jbam_pkg.sv =====
package jbam_pkg;

    // fixed field widths
    localparam int LVL_W    = 14;
    localparam int SAMPLE_W = 16;
    localparam int FRAME_W  = 2 * SAMPLE_W;
    localparam int FCNT_W   = 7;

    // saturation bounds of one output sample
    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;

    // reset values of the level registers
    localparam logic [LVL_W-1:0] PRIME_RESET = 14'd960;
    localparam logic [LVL_W-1:0] HIGH_RESET  = 14'd4800;

    typedef logic [LVL_W-1:0] lvl_t;

    // configuration register indexes
    typedef logic [0:0] cfg_idx_t;
    localparam cfg_idx_t CFG_PRIME = 1'b0;
    localparam cfg_idx_t CFG_HIGH  = 1'b1;

    // request codes
    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_MIX   = 2'd1,
        REQ_RESET = 2'd2
    } req_type_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_STREAM,
        ST_DRAIN,
        ST_UPDATE,
        ST_TRIM,
        ST_OUT_READ,
        ST_OUT_WAIT
    } state_t;

    // accumulator command issued with each streamed frame
    typedef struct packed {
        logic wr;    // write back the sum of this slot
        logic init;  // first source: start the slot from zero
        logic take;  // add the ring frame, otherwise add zero
    } acc_op_t;

endpackage

// ===== rtl/jbam_if.sv =====
// request channel
interface jbam_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [1:0]  source_id;
    logic signed [15:0] in_left;
    logic signed [15:0] in_right;
    logic        silent;
    logic [6:0]  frame_count;

    modport source (
        output valid, req_type, source_id, in_left, in_right, silent, frame_count,
        input  ready
    );
    modport sink (
        input  valid, req_type, source_id, in_left, in_right, silent, frame_count,
        output ready
    );
endinterface

// mixed frame channel
interface jbam_res_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;
    logic        last;

    modport source (
        output valid, out_left, out_right, last,
        input  ready
    );
    modport sink (
        input  valid, out_left, out_right, last,
        output ready
    );
endinterface

// ===== rtl/jbam_acc.sv =====
module jbam_acc #(
    parameter int MAX_BATCH = 64,
    parameter int ACC_W     = 18,
    parameter int IDX_W     = 6
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  jbam_pkg::acc_op_t               op,
    input  logic [IDX_W-1:0]                idx,
    input  logic [jbam_pkg::FRAME_W-1:0]    frame_word,
    output logic signed [jbam_pkg::SAMPLE_W-1:0] sum_left,
    output logic signed [jbam_pkg::SAMPLE_W-1:0] sum_right
);
    import jbam_pkg::*;

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(SAMPLE_MAX);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(SAMPLE_MIN);

    // per-slot running sums, right in the upper half
    logic [2*ACC_W-1:0] acc_mem [MAX_BATCH];
    logic [2*ACC_W-1:0] rd_reg;
    acc_op_t            p_op_reg;
    logic [IDX_W-1:0]   p_idx_reg;

    logic signed [ACC_W-1:0] base_l, base_r, samp_l, samp_r, new_l, new_r;

    function automatic logic signed [SAMPLE_W-1:0] sat(input logic signed [ACC_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > SAT_MAX)
            r = SAMPLE_W'(SAT_MAX);
        else if (v < SAT_MIN)
            r = SAMPLE_W'(SAT_MIN);
        else
            r = SAMPLE_W'(v);
        return r;
    endfunction

    // command is registered to line up with the registered memory read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_op_reg <= '0;
        end
        else
        begin
            p_op_reg <= op;
        end
    end

    always_ff @(posedge clk)
    begin
        p_idx_reg <= idx;
    end

    // add the streamed frame to the registered read of its slot
    always_comb
    begin
        base_l = p_op_reg.init ? '0 : $signed(rd_reg[ACC_W-1:0]);
        base_r = p_op_reg.init ? '0 : $signed(rd_reg[2*ACC_W-1:ACC_W]);
        samp_l = p_op_reg.take
            ? $signed({{(ACC_W-SAMPLE_W){frame_word[SAMPLE_W-1]}}, frame_word[SAMPLE_W-1:0]})
            : '0;
        samp_r = p_op_reg.take
            ? $signed({{(ACC_W-SAMPLE_W){frame_word[FRAME_W-1]}},
                       frame_word[FRAME_W-1:SAMPLE_W]})
            : '0;
        new_l = base_l + samp_l;
        new_r = base_r + samp_r;
    end

    // accumulator memory, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (p_op_reg.wr)
            acc_mem[p_idx_reg] <= {new_r, new_l};
        rd_reg <= acc_mem[idx];
    end

    // clamp the slot just read for output
    assign sum_left  = sat($signed(rd_reg[ACC_W-1:0]));
    assign sum_right = sat($signed(rd_reg[2*ACC_W-1:ACC_W]));

endmodule

// ===== rtl/jitter_buffer_audio_mixer.sv =====
// Stereo jitter buffer and mixer. Every source owns a ring of RING_FRAMES frames in one
// shared frame memory; pushes write one frame, mix requests sum up to MAX_BATCH frames of
// all primed sources into an accumulator memory and then deliver them one by one with
// 16-bit saturation. For each source a mix passes through setup, stream, drain, update
// and trim states; a source streams one frame a cycle through the single read port of
// the frame memory into a read-modify-write of the accumulator, and every result then
// needs one accumulator read and one output load, which waits while the result side
// stalls. The frame memory needs no clearing after reset; only frames pushed since a
// source was reset are read.
module jitter_buffer_audio_mixer #(
    parameter int SOURCES     = 4,
    parameter int RING_FRAMES = 8192,
    parameter int MAX_BATCH   = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  jbam_pkg::cfg_idx_t   cfg_index,
    input  jbam_pkg::lvl_t       cfg_data,
    jbam_req_if.sink             req,
    jbam_res_if.source           res
);
    import jbam_pkg::*;

    localparam int SRC_W  = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int POS_W  = $clog2(RING_FRAMES);
    localparam int FILL_W = $clog2(RING_FRAMES + 1);
    localparam int SUM_W  = FILL_W + 1;
    localparam int ADDR_W = $clog2(SOURCES * RING_FRAMES);
    localparam int IDX_W  = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
    localparam int CNT_W  = $clog2(MAX_BATCH + 1);
    localparam int CMP_W  = (FILL_W > LVL_W) ? FILL_W : LVL_W;
    localparam int ACC_W  = SAMPLE_W + SRC_W;

    state_t state_reg, state_next;

    lvl_t prime_reg, high_reg;

    // per-source ring control
    logic [POS_W-1:0]  rp_reg     [SOURCES];
    logic [POS_W-1:0]  wp_reg     [SOURCES];
    logic [FILL_W-1:0] fill_reg   [SOURCES];
    logic              primed_reg [SOURCES];

    // mix sequencing
    logic [CNT_W-1:0] frames_reg, n_reg;
    logic [SRC_W-1:0] src_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             part_reg, full_reg;

    // frame memory
    logic [FRAME_W-1:0] ring_mem [SOURCES * RING_FRAMES];
    logic [FRAME_W-1:0] ring_rd_reg;
    logic [FRAME_W-1:0] ring_wd;
    logic [ADDR_W-1:0]  ring_wa, ring_ra;
    logic               ring_we;

    // output register
    logic                       out_valid_reg, out_last_reg;
    logic signed [SAMPLE_W-1:0] out_left_reg, out_right_reg;
    logic signed [SAMPLE_W-1:0] sum_left, sum_right;

    acc_op_t acc_op;

    logic              req_acc, src_ok;
    logic [SRC_W-1:0]  in_src, cur_src;
    logic [POS_W-1:0]  rp_cur, wp_cur, wp_inc, rd_off, rp_adv, rp_trim;
    logic [FILL_W-1:0] fill_cur;
    logic [CMP_W-1:0]  fill_x, prime_x, high_x, adv_x;
    logic              part_now, trim_now, stream_last, src_last, out_last_now, out_load;
    logic [CNT_W-1:0]  n_now;
    logic [FCNT_W-1:0] fc_clamp;

    function automatic logic [POS_W-1:0] wrap_pos(input logic [SUM_W-1:0] v);
        logic [POS_W-1:0] r;
        if (v >= SUM_W'(RING_FRAMES))
            r = POS_W'(v - SUM_W'(RING_FRAMES));
        else
            r = POS_W'(v);
        return r;
    endfunction

    // request decode and selected source
    assign req_acc  = req.valid && req.ready;
    assign src_ok   = (int'(req.source_id) < SOURCES);
    assign in_src   = SRC_W'(req.source_id);
    assign cur_src  = (state_reg == ST_IDLE) ? in_src : src_reg;
    assign rp_cur   = rp_reg[cur_src];
    assign wp_cur   = wp_reg[cur_src];
    assign fill_cur = fill_reg[cur_src];
    assign fill_x   = CMP_W'(fill_cur);
    assign prime_x  = CMP_W'(prime_reg);
    assign high_x   = CMP_W'(high_reg);
    assign fc_clamp = (req.frame_count > FCNT_W'(MAX_BATCH)) ? FCNT_W'(MAX_BATCH)
                                                             : req.frame_count;

    // pointer arithmetic
    assign wp_inc  = wrap_pos(SUM_W'(wp_cur) + SUM_W'(1));
    assign rd_off  = wrap_pos(SUM_W'(rp_cur) + SUM_W'(idx_reg));
    assign rp_adv  = wrap_pos(SUM_W'(rp_cur) + SUM_W'(n_reg));
    assign adv_x   = fill_x - prime_x;
    assign rp_trim = wrap_pos(SUM_W'(rp_cur) + SUM_W'(adv_x));

    // per-source decisions of a mix
    assign part_now     = primed_reg[src_reg] || (fill_x >= prime_x);
    assign n_now        = (fill_cur < FILL_W'(frames_reg)) ? CNT_W'(fill_cur) : frames_reg;
    assign trim_now     = full_reg && (fill_x > high_x) && (fill_x > prime_x);
    assign stream_last  = (CNT_W'(idx_reg) == frames_reg - CNT_W'(1));
    assign src_last     = (src_reg == SRC_W'(SOURCES - 1));
    assign out_last_now = stream_last;
    assign out_load     = (state_reg == ST_OUT_WAIT) && (!out_valid_reg || res.ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (req_acc && (req.req_type == REQ_MIX) && (req.frame_count != '0))
                    state_next = ST_SETUP;
            ST_SETUP:    state_next = ST_STREAM;
            ST_STREAM:
                if (stream_last)
                    state_next = ST_DRAIN;
            ST_DRAIN:    state_next = ST_UPDATE;
            ST_UPDATE:   state_next = ST_TRIM;
            ST_TRIM:     state_next = src_last ? ST_OUT_READ : ST_SETUP;
            ST_OUT_READ: state_next = ST_OUT_WAIT;
            ST_OUT_WAIT:
                if (out_load)
                    state_next = out_last_now ? ST_IDLE : ST_OUT_READ;
            default:     state_next = ST_IDLE;
        endcase
    end

    // state outputs: handshake, memory ports, accumulator command
    always_comb
    begin
        req.ready   = (state_reg == ST_IDLE);
        ring_we     = req_acc && src_ok && (req.req_type == REQ_PUSH);
        ring_wd     = req.silent ? '0 : {req.in_right, req.in_left};
        ring_wa     = ADDR_W'(in_src) * ADDR_W'(RING_FRAMES) + ADDR_W'(wp_cur);
        ring_ra     = ADDR_W'(src_reg) * ADDR_W'(RING_FRAMES) + ADDR_W'(rd_off);
        acc_op      = '0;
        case (state_reg)
            ST_STREAM:
            begin
                acc_op.wr   = 1'b1;
                acc_op.init = (src_reg == '0);
                acc_op.take = part_reg && (CNT_W'(idx_reg) < n_reg);
            end
            default: acc_op = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // level registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_reg <= PRIME_RESET;
            high_reg  <= HIGH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PRIME: prime_reg <= cfg_data;
                CFG_HIGH:  high_reg  <= cfg_data;
                default:   ;
            endcase
        end
    end

    // per-source ring control updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SOURCES; k++)
            begin
                rp_reg[k]     <= '0;
                wp_reg[k]     <= '0;
                fill_reg[k]   <= '0;
                primed_reg[k] <= 1'b0;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                    if (req_acc && src_ok)
                    begin
                        case (req.req_type)
                            REQ_PUSH:
                            begin
                                wp_reg[in_src] <= wp_inc;
                                if (fill_cur == FILL_W'(RING_FRAMES))
                                    rp_reg[in_src] <= wp_inc;
                                else
                                    fill_reg[in_src] <= fill_cur + FILL_W'(1);
                            end
                            REQ_RESET:
                            begin
                                rp_reg[in_src]     <= '0;
                                wp_reg[in_src]     <= '0;
                                fill_reg[in_src]   <= '0;
                                primed_reg[in_src] <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                ST_SETUP:
                    if (part_now)
                        primed_reg[src_reg] <= 1'b1;
                ST_UPDATE:
                    if (part_reg)
                    begin
                        rp_reg[src_reg]     <= rp_adv;
                        fill_reg[src_reg]   <= fill_cur - FILL_W'(n_reg);
                        primed_reg[src_reg] <= (n_reg == frames_reg);
                    end
                ST_TRIM:
                    if (trim_now)
                    begin
                        rp_reg[src_reg]   <= rp_trim;
                        fill_reg[src_reg] <= FILL_W'(prime_x);
                    end
                default: ;
            endcase
        end
    end

    // mix sequencing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= '0;
            n_reg      <= '0;
            src_reg    <= '0;
            idx_reg    <= '0;
            part_reg   <= 1'b0;
            full_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    frames_reg <= CNT_W'(fc_clamp);
                    src_reg    <= '0;
                end
                ST_SETUP:
                begin
                    part_reg <= part_now;
                    n_reg    <= n_now;
                    idx_reg  <= '0;
                end
                ST_STREAM:
                    if (!stream_last)
                        idx_reg <= idx_reg + IDX_W'(1);
                ST_UPDATE:
                    full_reg <= part_reg && (n_reg == frames_reg);
                ST_TRIM:
                begin
                    idx_reg <= '0;
                    if (!src_last)
                        src_reg <= src_reg + SRC_W'(1);
                end
                ST_OUT_WAIT:
                    if (out_load && !out_last_now)
                        idx_reg <= idx_reg + IDX_W'(1);
                default: ;
            endcase
        end
    end

    // frame memory, push writes and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[ring_wa] <= ring_wd;
        ring_rd_reg <= ring_mem[ring_ra];
    end

    jbam_acc #(
        .MAX_BATCH (MAX_BATCH),
        .ACC_W     (ACC_W),
        .IDX_W     (IDX_W)
    ) u_acc (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (acc_op),
        .idx        (idx_reg),
        .frame_word (ring_rd_reg),
        .sum_left   (sum_left),
        .sum_right  (sum_right)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_left_reg  <= sum_left;
            out_right_reg <= sum_right;
            out_last_reg  <= out_last_now;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.out_left  = out_left_reg;
    assign res.out_right = out_right_reg;
    assign res.last      = out_last_reg;

`ifndef ASSERT_OFF
    // a source never holds more frames than its ring
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_cur <= FILL_W'(RING_FRAMES))
        else $error("fill count above ring size");

    // a new item only appears from the output load state
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT_WAIT))
        else $error("output item loaded outside the output phase");

    // loading the final frame of a batch ends the mix
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_last_now) |=> (state_reg == ST_IDLE) && out_last_reg)
        else $error("mix did not end after its last frame");
`endif

endmodule

// ===== dv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jbam_pkg::*;

    localparam int NUM_SRC   = 4;
    localparam int RING_LEN  = 8192;
    localparam int BATCH_MAX = 64;
    localparam int PTR_W     = $clog2(RING_LEN);
    localparam int SETTLE    = 40;
    localparam int PHASES    = 6;

    // request code the block must ignore
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    // level settings walked by the random phases
    localparam int PRIME_SEQ [PHASES] = '{0, 1, 3, 8, 16383, 4};
    localparam int HIGH_SEQ  [PHASES] = '{0, 16383, 8, 2, 16383, 12};

    typedef struct {
        logic [1:0]         kind;
        logic [1:0]         src;
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               silent;
        logic [6:0]         nframes;
    } mix_req_t;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               last;
    } mix_frame_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     cfg_we;
    cfg_idx_t cfg_index;
    lvl_t     cfg_data;

    jbam_req_if req_ch ();
    jbam_res_if mix_ch ();

    jitter_buffer_audio_mixer #(
        .SOURCES     (NUM_SRC),
        .RING_FRAMES (RING_LEN),
        .MAX_BATCH   (BATCH_MAX)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .res       (mix_ch)
    );

    // buffer and mixer shadow state
    logic [31:0]      ring_mem [NUM_SRC][RING_LEN];
    logic [PTR_W-1:0] rd_ptr [NUM_SRC];
    logic [PTR_W-1:0] wr_ptr [NUM_SRC];
    int               fill [NUM_SRC];
    bit               primed [NUM_SRC];
    int               prime_lvl;
    int               high_lvl;

    mix_req_t   req_backlog [$];
    mix_frame_t mix_frames_due [$];
    int         fail_count;
    bit         req_taken;

    int          burst_left;
    int          gap_left;
    logic [5:0]  pace_tick = '0;
    logic [31:0] ready_mask = '1;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [15:0] clip16(input int v);
        if (v > SAMPLE_MAX)
            return 16'(SAMPLE_MAX);
        if (v < SAMPLE_MIN)
            return 16'(SAMPLE_MIN);
        return 16'(v);
    endfunction

    // full-scale values show up often
    function automatic logic [15:0] pick_sample();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 16'h7fff;
        if (r == 1)
            return 16'h8000;
        return 16'($urandom);
    endfunction

    // mostly short batches, some longer ones up to full, rare empty and oversized ones
    function automatic logic [6:0] pick_batch();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 7'($urandom_range(1, 8));
        if (r < 88)
            return 7'($urandom_range(9, BATCH_MAX));
        if (r < 94)
            return 7'd0;
        return 7'($urandom_range(BATCH_MAX + 1, 127));
    endfunction

    // every field random; callers override the ones that matter
    function automatic mix_req_t junk_req();
        mix_req_t rq;
        rq.kind    = 2'($urandom);
        rq.src     = 2'($urandom);
        rq.left    = 16'($urandom);
        rq.right   = 16'($urandom);
        rq.silent  = 1'($urandom);
        rq.nframes = 7'($urandom);
        return rq;
    endfunction

    task automatic queue_push(input logic [1:0] src, input logic [15:0] l,
                              input logic [15:0] r, input logic sil);
        mix_req_t rq;
        rq        = junk_req();
        rq.kind   = REQ_PUSH;
        rq.src    = src;
        rq.left   = l;
        rq.right  = r;
        rq.silent = sil;
        req_backlog.insert(req_backlog.size(), rq);
    endtask

    task automatic queue_mix(input logic [6:0] n);
        mix_req_t rq;
        rq         = junk_req();
        rq.kind    = REQ_MIX;
        rq.nframes = n;
        req_backlog.insert(req_backlog.size(), rq);
    endtask

    task automatic queue_reset(input logic [1:0] src);
        mix_req_t rq;
        rq      = junk_req();
        rq.kind = REQ_RESET;
        rq.src  = src;
        req_backlog.insert(req_backlog.size(), rq);
    endtask

    // runs of pushes into one source, mixes, source resets and noise
    task automatic queue_random_items(input int count);
        int         made;
        int         pick;
        int         run;
        logic [1:0] src;
        mix_req_t   rq;
        made = 0;
        while (made < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                src = 2'($urandom);
                run = $urandom_range(1, 12);
                repeat (run)
                    queue_push(src, pick_sample(), pick_sample(), $urandom_range(0, 9) == 0);
                made += run;
            end
            else
            begin
                if (pick < 85)
                    queue_mix(pick_batch());
                else if (pick < 93)
                    queue_reset(2'($urandom));
                else
                begin
                    rq      = junk_req();
                    rq.kind = REQ_UNKNOWN;
                    req_backlog.insert(req_backlog.size(), rq);
                end
                made++;
            end
        end
    endtask

    // advance the shadow state by one accepted item, queue the frames it yields
    task automatic mixer_advance(input mix_req_t rq);
        int          acc_l [BATCH_MAX];
        int          acc_r [BATCH_MAX];
        int          want;
        int          take;
        logic [31:0] word;
        mix_frame_t  fr;
        case (rq.kind)
            REQ_PUSH:
            begin
                word = rq.silent ? 32'd0 : {rq.right, rq.left};
                ring_mem[rq.src][wr_ptr[rq.src]] = word;
                wr_ptr[rq.src] = wr_ptr[rq.src] + 1'b1;
                // full ring: oldest frame is overwritten
                if (fill[rq.src] == RING_LEN)
                    rd_ptr[rq.src] = wr_ptr[rq.src];
                else
                    fill[rq.src]++;
            end
            REQ_RESET:
            begin
                rd_ptr[rq.src] = '0;
                wr_ptr[rq.src] = '0;
                fill[rq.src]   = 0;
                primed[rq.src] = 1'b0;
            end
            REQ_MIX:
            begin
                want = rq.nframes;
                if (want > BATCH_MAX)
                    want = BATCH_MAX;
                if (want != 0)
                begin
                    for (int i = 0; i < want; i++)
                    begin
                        acc_l[i] = 0;
                        acc_r[i] = 0;
                    end
                    for (int s = 0; s < NUM_SRC; s++)
                    begin
                        if (!primed[s] && fill[s] >= prime_lvl)
                            primed[s] = 1'b1;
                        if (primed[s])
                        begin
                            take = (fill[s] < want) ? fill[s] : want;
                            for (int i = 0; i < take; i++)
                            begin
                                word = ring_mem[s][rd_ptr[s]];
                                acc_l[i] = acc_l[i] + $signed(word[15:0]);
                                acc_r[i] = acc_r[i] + $signed(word[31:16]);
                                rd_ptr[s] = rd_ptr[s] + 1'b1;
                            end
                            fill[s] -= take;
                            // short source drops out; a deep one skips back to prime level
                            if (take < want)
                                primed[s] = 1'b0;
                            else if (fill[s] > high_lvl && fill[s] > prime_lvl)
                            begin
                                rd_ptr[s] = PTR_W'(rd_ptr[s] + (fill[s] - prime_lvl));
                                fill[s]   = prime_lvl;
                            end
                        end
                    end
                    for (int i = 0; i < want; i++)
                    begin
                        fr.left  = clip16(acc_l[i]);
                        fr.right = clip16(acc_r[i]);
                        fr.last  = (i == want - 1);
                        mix_frames_due.insert(mix_frames_due.size(), fr);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic set_levels(input int p, input int h);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PRIME;
        cfg_data  <= lvl_t'(p);
        @(negedge clk);
        cfg_index <= CFG_HIGH;
        cfg_data  <= lvl_t'(h);
        @(negedge clk);
        cfg_we    <= 1'b0;
        prime_lvl = p;
        high_lvl  = h;
    endtask

    // everything sent, every frame back, then let the block settle
    task automatic wait_idle();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (req_backlog.size() != 0 || req_ch.valid || mix_frames_due.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // request driver: bursts of items separated by random gaps
    always @(negedge clk)
    begin : drive_req
        mix_req_t rq;
        if (rst_n)
        begin
            if (!req_ch.valid || req_taken)
            begin
                req_taken = 1'b0;
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end
                else if (req_backlog.size() != 0)
                begin
                    rq = req_backlog.pop_front();
                    req_ch.valid       <= 1'b1;
                    req_ch.req_type    <= rq.kind;
                    req_ch.source_id   <= rq.src;
                    req_ch.in_left     <= rq.left;
                    req_ch.in_right    <= rq.right;
                    req_ch.silent      <= rq.silent;
                    req_ch.frame_count <= rq.nframes;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // result ready follows a rotating mask, redrawn each time the 6-bit tick counter wraps
    always @(negedge clk)
    begin : pace_res
        int mode;
        if (rst_n)
        begin
            if (pace_tick == '0)
            begin
                mode = $urandom_range(0, 9);
                if (mode < 3)
                    ready_mask = '1;
                else if (mode < 8)
                    ready_mask = $urandom;
                else
                    ready_mask = $urandom & $urandom;
            end
            pace_tick = pace_tick + 1'b1;
            mix_ch.ready <= ready_mask[0];
            ready_mask = {ready_mask[0], ready_mask[31:1]};
        end
    end

    // accepted requests feed the shadow model, accepted frames are checked
    always @(posedge clk)
    begin : watch
        mix_req_t   rq;
        mix_frame_t due;
        if (rst_n)
        begin
            if (mix_ch.valid && mix_ch.ready)
            begin
                if (mix_frames_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: expected no frame, got L=%0d R=%0d last=%0b", $time,
                             mix_ch.out_left, mix_ch.out_right, mix_ch.last);
                end
                else
                begin
                    due = mix_frames_due.pop_front();
                    if (mix_ch.out_left !== due.left || mix_ch.out_right !== due.right ||
                        mix_ch.last !== due.last)
                    begin
                        fail_count++;
                        $display("%0t: expected %0d/%0d/%0b got %0d/%0d/%0b",
                                 $time, due.left, due.right, due.last,
                                 mix_ch.out_left, mix_ch.out_right, mix_ch.last);
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                rq.kind    = req_ch.req_type;
                rq.src     = req_ch.source_id;
                rq.left    = req_ch.in_left;
                rq.right   = req_ch.in_right;
                rq.silent  = req_ch.silent;
                rq.nframes = req_ch.frame_count;
                mixer_advance(rq);
                req_taken = 1'b1;
            end
        end
    end

    initial
    begin
        #50_000_000;
        $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        mix_req_t rq;

        // known levels on every input from time zero
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_PRIME;
        cfg_data           = '0;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_PUSH;
        req_ch.source_id   = '0;
        req_ch.in_left     = '0;
        req_ch.in_right    = '0;
        req_ch.silent      = 1'b0;
        req_ch.frame_count = '0;
        mix_ch.ready       = 1'b0;
        fail_count         = 0;
        req_taken          = 1'b0;
        burst_left         = 0;
        gap_left           = 0;
        for (int s = 0; s < NUM_SRC; s++)
        begin
            rd_ptr[s] = '0;
            wr_ptr[s] = '0;
            fill[s]   = 0;
            primed[s] = 1'b0;
        end
        prime_lvl = PRIME_RESET;
        high_lvl  = HIGH_RESET;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // power-on levels: nothing primed, empty and oversized batches, ignored code
        queue_mix(7'd3);
        queue_mix(7'd0);
        rq      = junk_req();
        rq.kind = REQ_UNKNOWN;
        req_backlog.insert(req_backlog.size(), rq);
        queue_push(2'd0, 16'h7fff, 16'h8000, 1'b0);
        queue_reset(2'd0);
        queue_mix(7'd127);
        wait_idle();

        // low levels: saturation both ways, silent push, short source, skip down
        set_levels(2, 4);
        queue_push(2'd0, 16'h7fff, 16'h8000, 1'b0);
        queue_push(2'd0, 16'hffff, 16'hffff, 1'b1);
        queue_push(2'd1, 16'h7fff, 16'h7fff, 1'b0);
        queue_push(2'd1, 16'h7fff, 16'h7fff, 1'b0);
        queue_push(2'd2, 16'h7fff, 16'h7fff, 1'b0);
        queue_push(2'd2, 16'h7fff, 16'h7fff, 1'b0);
        queue_mix(7'd2);
        for (int s = 1; s < NUM_SRC; s++)
        begin
            queue_push(2'(s), 16'h8000, 16'h8000, 1'b0);
            queue_push(2'(s), 16'h8000, 16'h8000, 1'b0);
        end
        queue_mix(7'd2);
        queue_push(2'd3, 16'd100, 16'hff9c, 1'b0);
        queue_push(2'd3, 16'd100, 16'hff9c, 1'b0);
        queue_mix(7'd5);
        repeat (7)
            queue_push(2'd0, pick_sample(), pick_sample(), 1'b0);
        queue_mix(7'd1);
        queue_mix(7'd2);
        wait_idle();

        // random traffic under a range of level settings
        for (int p = 0; p < PHASES; p++)
        begin
            set_levels(PRIME_SEQ[p], HIGH_SEQ[p]);
            queue_random_items(35);
            wait_idle();
        end

        // one deep source is skipped back to the prime level, then runs short
        set_levels(16, 100);
        queue_reset(2'd1);
        for (int k = 0; k < 120; k++)
            queue_push(2'd1, pick_sample(), pick_sample(), $urandom_range(0, 19) == 0);
        queue_mix(7'd1);
        queue_mix(7'(BATCH_MAX));
        queue_random_items(30);
        wait_idle();

        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
